FILE: design/vtsp_pkg.sv
// Shared types and constants for the versioned token stream parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package vtsp_pkg;

  // Largest token payload the parser accepts, in bytes
  localparam int MaxPayloadBytes = 16;

  // Fixed field widths
  localparam int ByteW   = 8;
  localparam int LenW    = 16;
  localparam int PosW    = 4;
  localparam int CfgIdxW = 3;

  // Payload lengths of the address tokens
  localparam logic [5:0] LenIpv4 = 6'd4;
  localparam logic [5:0] LenIpv6 = 6'd16;

  // Address kinds, also the bits of the seen mask
  localparam logic KindIpv4 = 1'b0;
  localparam logic KindIpv6 = 1'b1;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSupMajor = 3'd0,
    CfgSupMinor = 3'd1,
    CfgCodeIpv4 = 3'd2,
    CfgCodeIpv6 = 3'd3,
    CfgCodeProxy = 3'd4
  } cfg_idx_e;

  // Result status codes
  typedef enum logic [2:0] {
    StBusy     = 3'd0,
    StOk       = 3'd1,
    StVersion  = 3'd2,
    StLength   = 3'd3,
    StConflict = 3'd4,
    StIgnored  = 3'd5
  } status_e;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [ByteW-1:0] sup_major;
    logic [ByteW-1:0] sup_minor;
    logic [ByteW-1:0] code_ipv4;
    logic [ByteW-1:0] code_ipv6;
    logic [ByteW-1:0] code_proxy;
  } cfg_t;

  // One result item
  typedef struct packed {
    status_e          status;
    logic             payload_valid;
    logic             payload_kind;
    logic [PosW-1:0]  payload_index;
    logic [ByteW-1:0] payload_byte;
    logic             payload_last;
    logic             proxy_seen;
  } result_t;

endpackage

`default_nettype wire

FILE: design/vtsp_cfg_regs.sv
// Configuration register file of the token stream parser.
// Depends on vtsp_pkg for the register indexes and the cfg_t struct.
`default_nettype none

module vtsp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [vtsp_pkg::CfgIdxW-1:0]  wr_index_i,
  input  logic [vtsp_pkg::ByteW-1:0]    wr_data_i,
  output vtsp_pkg::cfg_t                cfg_o
);
  import vtsp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the write index; unknown indexes drop the transfer
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CfgSupMajor:  cfg_d.sup_major  = wr_data_i;
        CfgSupMinor:  cfg_d.sup_minor  = wr_data_i;
        CfgCodeIpv4:  cfg_d.code_ipv4  = wr_data_i;
        CfgCodeIpv6:  cfg_d.code_ipv6  = wr_data_i;
        CfgCodeProxy: cfg_d.code_proxy = wr_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sup_major  <= 8'd1;
      cfg_q.sup_minor  <= 8'd0;
      cfg_q.code_ipv4  <= 8'd1;
      cfg_q.code_ipv6  <= 8'd2;
      cfg_q.code_proxy <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/vtsp_parser.sv
// Parser state and per-byte decision logic of the token stream parser.
// Depends on vtsp_pkg; the result is combinational and registered by the caller.
`default_nettype none

module vtsp_parser #(
  parameter int MAX_PAYLOAD_BYTES = vtsp_pkg::MaxPayloadBytes
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [vtsp_pkg::ByteW-1:0]  byte_i,
  input  logic                        start_i,
  input  vtsp_pkg::cfg_t              cfg_i,
  output vtsp_pkg::result_t           res_o
);
  import vtsp_pkg::*;

  localparam int         PlW    = $clog2(MAX_PAYLOAD_BYTES + 1);
  localparam logic [5:0] MaxLen = 6'(MAX_PAYLOAD_BYTES);

  typedef enum logic [2:0] {
    PhIdle, PhHeader, PhType, PhPayload, PhDone
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [1:0]       hcnt_q, hcnt_d;
  logic [ByteW-1:0] major_q, major_d;
  logic [ByteW-1:0] minor_q, minor_d;
  logic [LenW-1:0]  left_q, left_d;
  logic [PlW-1:0]   pleft_q, pleft_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             kind_q, kind_d;
  logic [1:0]       seen_q, seen_d;

  logic            is4, is6, isp;
  logic [5:0]      len;
  logic [LenW-1:0] left_dec;
  logic [1:0]      seen_new;
  result_t         res;

  // Classify the type byte; IPv4 beats IPv6 beats proxy on equal codes
  assign is4 = (byte_i == cfg_i.code_ipv4);
  assign is6 = !is4 && (byte_i == cfg_i.code_ipv6);
  assign isp = !is4 && !is6 && (byte_i == cfg_i.code_proxy);

  assign len = (major_q != cfg_i.sup_major) ? 6'd0 :
               is4 ? LenIpv4 : (is6 ? LenIpv6 : 6'd0);
  assign left_dec = left_q - LenW'(1);
  assign seen_new = seen_q | {is6, is4};

  // Next state and result for one byte
  always_comb begin
    phase_d = phase_q;
    hcnt_d  = hcnt_q;
    major_d = major_q;
    minor_d = minor_q;
    left_d  = left_q;
    pleft_d = pleft_q;
    pos_d   = pos_q;
    kind_d  = kind_q;
    seen_d  = seen_q;
    res     = '0;
    res.status = StBusy;

    if (start_i) begin
      // Restart the stream; the byte is the major version
      hcnt_d  = 2'd0;
      minor_d = '0;
      left_d  = '0;
      pleft_d = '0;
      pos_d   = '0;
      kind_d  = 1'b0;
      seen_d  = '0;
      major_d = byte_i;
      if (byte_i > cfg_i.sup_major) begin
        phase_d    = PhDone;
        res.status = StVersion;
      end else begin
        phase_d = PhHeader;
        hcnt_d  = 2'd1;
      end
    end else begin
      unique case (phase_q)
        PhHeader: begin
          if (hcnt_q == 2'd1) begin
            minor_d = byte_i;
            hcnt_d  = 2'd2;
          end else if (hcnt_q == 2'd2) begin
            left_d = {8'd0, byte_i};
            hcnt_d = 2'd3;
          end else begin
            left_d = {byte_i, left_q[7:0]};
            hcnt_d = 2'd0;
            if ({byte_i, left_q[7:0]} == '0) begin
              phase_d    = PhDone;
              res.status = StOk;
            end else begin
              phase_d = PhType;
            end
          end
        end
        PhType: begin
          left_d = left_dec;
          if (len == 6'd0 && minor_q > cfg_i.sup_minor) begin
            // Unknown token from a newer minor ends the stream cleanly
            phase_d    = PhDone;
            res.status = StOk;
          end else if ({10'd0, len} > left_dec || len > MaxLen) begin
            phase_d    = PhDone;
            res.status = StLength;
          end else begin
            seen_d = seen_new;
            if (seen_new == 2'b11) begin
              phase_d    = PhDone;
              res.status = StConflict;
            end else begin
              res.proxy_seen = isp;
              if (len != 6'd0) begin
                pleft_d = PlW'(len);
                pos_d   = '0;
                kind_d  = is6 ? KindIpv6 : KindIpv4;
                phase_d = PhPayload;
              end else if (left_dec == '0) begin
                phase_d    = PhDone;
                res.status = StOk;
              end
            end
          end
        end
        PhPayload: begin
          res.payload_valid = 1'b1;
          res.payload_kind  = kind_q;
          res.payload_index = pos_q;
          res.payload_byte  = byte_i;
          res.payload_last  = (pleft_q == PlW'(1));
          left_d  = left_dec;
          pleft_d = pleft_q - PlW'(1);
          pos_d   = pos_q + PosW'(1);
          if (pleft_q == PlW'(1)) begin
            if (left_dec == '0) begin
              phase_d    = PhDone;
              res.status = StOk;
            end else begin
              phase_d = PhType;
            end
          end
        end
        default: res.status = StIgnored;
      endcase
    end
  end

  // Hold parser state; advance only when a byte is consumed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      hcnt_q  <= '0;
      major_q <= '0;
      minor_q <= '0;
      left_q  <= '0;
      pleft_q <= '0;
      pos_q   <= '0;
      kind_q  <= 1'b0;
      seen_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      major_q <= major_d;
      minor_q <= minor_d;
      left_q  <= left_d;
      pleft_q <= pleft_d;
      pos_q   <= pos_d;
      kind_q  <= kind_d;
      seen_q  <= seen_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  // A payload phase always has bytes pending
  a_pleft_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> pleft_q != '0)
    else $error("payload phase with no payload bytes left");

  // Both address kinds are never recorded in an active stream
  a_no_dual_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhType || phase_q == PhPayload) |-> seen_q != 2'b11)
    else $error("both address kinds seen in an active stream");

  // Header counter stays nonzero while reading the header
  a_hcnt_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHeader |-> hcnt_q != 2'd0)
    else $error("header phase with header counter at zero");
`endif

endmodule

`default_nettype wire

FILE: design/versioned_token_stream_parser.sv
// Top level of the versioned token stream parser: input register, parser, result register.
// Depends on vtsp_pkg, vtsp_cfg_regs and vtsp_parser.
`default_nettype none

// Parses a trailer token stream one byte per transfer: a four-byte header (major, minor,
// 16-bit little-endian length) then typed tokens whose IPv4/IPv6 address bytes come out
// tagged with kind and position. Every input byte yields exactly one result. Throughput is
// one byte per cycle unless m_axis_tready stalls it; the input register and the result
// register hold each byte in turn, with the parser state update between them as the only
// loop. tuser is stream_start; it restarts the parser in any phase. Configuration writes
// are taken every cycle and must only be issued while no byte is in flight.

module versioned_token_stream_parser #(
  parameter int MAX_PAYLOAD_BYTES = vtsp_pkg::MaxPayloadBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vtsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vtsp_pkg::ByteW-1:0]    cfg_data_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tuser,  // [0] stream_start
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] status, [6:3] payload_index, [14:7] payload_byte, [15] proxy_seen
  output logic [15:0]                   m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,  // [0] payload_valid, [1] payload_kind
  output logic                          m_axis_tlast   // payload_last
);
  import vtsp_pkg::*;

  cfg_t    cfg;
  result_t res, res_q;

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q;
  logic             in_start_q;
  logic             out_valid_q, out_valid_d;
  logic             advance, s_xfer;

  assign cfg_ready_o = 1'b1;

  vtsp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Move the held byte into the result register when that slot frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  vtsp_parser #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .byte_i  (in_byte_q),
    .start_i (in_start_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  assign in_valid_d  = s_axis_tready ? s_axis_tvalid : in_valid_q;
  assign out_valid_d = advance ? 1'b1 : (out_valid_q && !m_axis_tready);

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.proxy_seen, res_q.payload_byte, res_q.payload_index,
                          res_q.status};
  assign m_axis_tuser  = {res_q.payload_kind, res_q.payload_valid};
  assign m_axis_tlast  = res_q.payload_last;

`ifndef SYNTHESIS
  // A held byte that cannot advance stays held
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input byte lost while stalled");

  // Address bytes only come with a busy or done status
  a_payload_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.payload_valid |-> res_q.status == StBusy || res_q.status == StOk)
    else $error("address byte with an error status");

  // Proxy flag and address byte never share a result
  a_proxy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.proxy_seen && res_q.payload_valid))
    else $error("proxy flag on an address byte");

  // Address fields are zero when no address byte is carried
  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.payload_valid |->
      res_q.payload_byte == '0 && res_q.payload_index == '0 && !res_q.payload_last &&
      !res_q.payload_kind)
    else $error("address fields set without an address byte");
`endif

endmodule

`default_nettype wire
